// File: src/dual_wheel_speed_regulator_defines.svh
// Assertion macros for the dual wheel speed regulator.
// Used by the top level only; the macros expect clk and rst_n in scope.
`ifndef DUAL_WHEEL_SPEED_REGULATOR_DEFINES_SVH
`define DUAL_WHEEL_SPEED_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DWSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DWSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dwsr_pkg.sv
// Shared types and constants of the dual wheel speed regulator.
// No dependencies; used by dwsr_step and dual_wheel_speed_regulator.
package dwsr_pkg;

    // Input action codes
    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_LEFT  = 3'd2,
        ACT_RIGHT = 3'd3,
        ACT_TICK  = 3'd4
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BURST,
        ST_TICK_L,
        ST_TICK_R,
        ST_TICK_OUT
    } state_t;

    // Register map (low nibble of the byte address)
    localparam logic [3:0] REG_ID        = 4'd0;
    localparam logic [3:0] REG_VERSION   = 4'd1;
    localparam logic [3:0] REG_L_DIR     = 4'd2;
    localparam logic [3:0] REG_L_TARGET  = 4'd3;
    localparam logic [3:0] REG_L_MEAS    = 4'd4;
    localparam logic [3:0] REG_L_DUTY    = 4'd5;
    localparam logic [3:0] REG_R_DIR     = 4'd6;
    localparam logic [3:0] REG_R_TARGET  = 4'd7;
    localparam logic [3:0] REG_R_MEAS    = 4'd8;
    localparam logic [3:0] REG_R_DUTY    = 4'd9;
    localparam logic [3:0] REG_LAST      = 4'd9;
    localparam logic [7:0] NUM_REGS      = 8'd10;

    localparam logic [7:0] DEVICE_ID     = 8'h4D;  // 'M'
    localparam logic [7:0] VERSION_ID    = 8'h32;  // '2'
    localparam logic [7:0] BYTE_MAX      = 8'hFF;

    // Result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_DRIVE = 1'b1;

    // Operands of the shared regulation step
    typedef struct packed {
        logic [7:0] measured;
        logic [7:0] target;
        logic [7:0] duty;
    } step_in_t;

endpackage

// File: src/dwsr_step.sv
// Shared duty step unit: moves a duty by one toward the target speed.
// Depends on dwsr_pkg; time-shared between both wheels by the top level.
module dwsr_step (
    input  dwsr_pkg::step_in_t op,
    output logic [7:0]         duty_out
);

    logic go_up;
    logic go_down;

    // Compare measured speed with target, respect duty limits
    always_comb
    begin
        go_up   = (op.measured < op.target) && (op.duty != dwsr_pkg::BYTE_MAX);
        go_down = (op.measured > op.target) && (op.duty != 8'd0);
        priority if (go_up)
        begin
            duty_out = op.duty + 8'd1;
        end
        else if (go_down)
        begin
            duty_out = op.duty - 8'd1;
        end
        else
        begin
            duty_out = op.duty;
        end
    end

endmodule

// File: src/dual_wheel_speed_regulator.sv
// Dual wheel speed regulator: register map, encoder counting and duty control.
// Depends on dwsr_pkg, dwsr_step and dual_wheel_speed_regulator_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, reg_addr, write_data.
//   Output channel (out_valid/out_ready) carries one result per transfer.
//   Register writes and encoder edges take effect in the transfer cycle and
//   give no result; the block is ready again on the next cycle.
//   A tick runs the single duty step unit over the left wheel, then the
//   right wheel (ST_TICK_L, ST_TICK_R); the drive result is loaded in
//   ST_TICK_OUT once the output register is free, then new items are taken.
//   A read burst emits one byte per cycle (1 to 10 bytes) from the output
//   register while it is free; the block is busy until the last byte is loaded.
//   The output register frees the input side: a new item is taken while the
//   final result still waits. If the receiver stalls, the sequencer holds
//   until the output register empties; nothing is dropped.
//   Reset (rst_n low, asynchronous) sets both directions to 1, clears
//   targets, speeds, duties, edge counts and out_valid; the payload is not reset.
`include "dual_wheel_speed_regulator_defines.svh"

module dual_wheel_speed_regulator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] reg_addr,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] read_data,
    output logic       last_byte,
    output logic [7:0] left_leg_a_duty,
    output logic [7:0] left_leg_b_duty,
    output logic [7:0] right_leg_a_duty,
    output logic [7:0] right_leg_b_duty
);

    dwsr_pkg::state_t state_reg, state_next;

    logic       left_dir_reg,     left_dir_next;
    logic [7:0] left_target_reg,  left_target_next;
    logic [7:0] left_meas_reg,    left_meas_next;
    logic [7:0] left_duty_reg,    left_duty_next;
    logic [7:0] left_count_reg,   left_count_next;
    logic       right_dir_reg,    right_dir_next;
    logic [7:0] right_target_reg, right_target_next;
    logic [7:0] right_meas_reg,   right_meas_next;
    logic [7:0] right_duty_reg,   right_duty_next;
    logic [7:0] right_count_reg,  right_count_next;

    logic [3:0] addr_reg, addr_next;
    logic       oor_reg,  oor_next;

    logic       out_valid_reg, out_valid_next;
    logic       kind_reg,  kind_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       last_reg,  last_next;
    logic [7:0] la_reg, la_next;
    logic [7:0] lb_reg, lb_next;
    logic [7:0] ra_reg, ra_next;
    logic [7:0] rb_reg, rb_next;

    logic               out_free;
    logic               in_xfer;
    logic               burst_last;
    logic [7:0]         reg_byte;
    dwsr_pkg::step_in_t step_op;
    logic [7:0]         step_duty;

    // Shared duty step, steered to one wheel at a time
    always_comb
    begin
        if (state_reg == dwsr_pkg::ST_TICK_R)
        begin
            step_op.measured = right_count_reg;
            step_op.target   = right_target_reg;
            step_op.duty     = right_duty_reg;
        end
        else
        begin
            step_op.measured = left_count_reg;
            step_op.target   = left_target_reg;
            step_op.duty     = left_duty_reg;
        end
    end

    dwsr_step u_step (
        .op       (step_op),
        .duty_out (step_duty)
    );

    // Register map read mux
    always_comb
    begin
        unique case (addr_reg)
            dwsr_pkg::REG_ID:       reg_byte = dwsr_pkg::DEVICE_ID;
            dwsr_pkg::REG_VERSION:  reg_byte = dwsr_pkg::VERSION_ID;
            dwsr_pkg::REG_L_DIR:    reg_byte = {7'd0, left_dir_reg};
            dwsr_pkg::REG_L_TARGET: reg_byte = left_target_reg;
            dwsr_pkg::REG_L_MEAS:   reg_byte = left_meas_reg;
            dwsr_pkg::REG_L_DUTY:   reg_byte = left_duty_reg;
            dwsr_pkg::REG_R_DIR:    reg_byte = {7'd0, right_dir_reg};
            dwsr_pkg::REG_R_TARGET: reg_byte = right_target_reg;
            dwsr_pkg::REG_R_MEAS:   reg_byte = right_meas_reg;
            dwsr_pkg::REG_R_DUTY:   reg_byte = right_duty_reg;
            default:                reg_byte = 8'd0;
        endcase
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == dwsr_pkg::ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign burst_last = oor_reg || (addr_reg == dwsr_pkg::REG_LAST);

    // Sequencer: next state, register updates and output loads
    always_comb
    begin
        state_next        = state_reg;
        left_dir_next     = left_dir_reg;
        left_target_next  = left_target_reg;
        left_meas_next    = left_meas_reg;
        left_duty_next    = left_duty_reg;
        left_count_next   = left_count_reg;
        right_dir_next    = right_dir_reg;
        right_target_next = right_target_reg;
        right_meas_next   = right_meas_reg;
        right_duty_next   = right_duty_reg;
        right_count_next  = right_count_reg;
        addr_next         = addr_reg;
        oor_next          = oor_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        kind_next         = kind_reg;
        rdata_next        = rdata_reg;
        last_next         = last_reg;
        la_next           = la_reg;
        lb_next           = lb_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;

        unique case (state_reg)
            dwsr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (dwsr_pkg::action_t'(action))
                        dwsr_pkg::ACT_WRITE:
                        begin
                            if (reg_addr[7:4] == 4'd0)
                            begin
                                unique case (reg_addr[3:0])
                                    dwsr_pkg::REG_L_DIR:
                                        left_dir_next = (write_data != 8'd0);
                                    dwsr_pkg::REG_R_DIR:
                                        right_dir_next = (write_data != 8'd0);
                                    dwsr_pkg::REG_L_TARGET:
                                    begin
                                        left_target_next = write_data;
                                        if (write_data == 8'd0)
                                        begin
                                            left_duty_next = 8'd0;
                                        end
                                    end
                                    dwsr_pkg::REG_R_TARGET:
                                    begin
                                        right_target_next = write_data;
                                        if (write_data == 8'd0)
                                        begin
                                            right_duty_next = 8'd0;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        dwsr_pkg::ACT_READ:
                        begin
                            addr_next  = reg_addr[3:0];
                            oor_next   = (reg_addr >= dwsr_pkg::NUM_REGS);
                            state_next = dwsr_pkg::ST_BURST;
                        end
                        dwsr_pkg::ACT_LEFT:
                        begin
                            if (left_count_reg != dwsr_pkg::BYTE_MAX)
                            begin
                                left_count_next = left_count_reg + 8'd1;
                            end
                        end
                        dwsr_pkg::ACT_RIGHT:
                        begin
                            if (right_count_reg != dwsr_pkg::BYTE_MAX)
                            begin
                                right_count_next = right_count_reg + 8'd1;
                            end
                        end
                        dwsr_pkg::ACT_TICK:
                            state_next = dwsr_pkg::ST_TICK_L;
                        default: ;
                    endcase
                end
            end

            dwsr_pkg::ST_BURST:
            begin
                // Emit one register byte per free output slot
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = dwsr_pkg::KIND_READ;
                    rdata_next     = oor_reg ? 8'd0 : reg_byte;
                    last_next      = burst_last;
                    la_next        = 8'd0;
                    lb_next        = 8'd0;
                    ra_next        = 8'd0;
                    rb_next        = 8'd0;
                    if (burst_last)
                    begin
                        state_next = dwsr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        addr_next = addr_reg + 4'd1;
                    end
                end
            end

            dwsr_pkg::ST_TICK_L:
            begin
                left_meas_next  = left_count_reg;
                left_count_next = 8'd0;
                left_duty_next  = step_duty;
                state_next      = dwsr_pkg::ST_TICK_R;
            end

            dwsr_pkg::ST_TICK_R:
            begin
                right_meas_next  = right_count_reg;
                right_count_next = 8'd0;
                right_duty_next  = step_duty;
                state_next       = dwsr_pkg::ST_TICK_OUT;
            end

            dwsr_pkg::ST_TICK_OUT:
            begin
                // Place each duty on the leg chosen by direction; a zero target drives neither leg
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = dwsr_pkg::KIND_DRIVE;
                    rdata_next     = 8'd0;
                    last_next      = 1'b0;
                    la_next        = 8'd0;
                    lb_next        = 8'd0;
                    ra_next        = 8'd0;
                    rb_next        = 8'd0;
                    if (left_target_reg != 8'd0)
                    begin
                        if (left_dir_reg)
                        begin
                            la_next = left_duty_reg;
                        end
                        else
                        begin
                            lb_next = left_duty_reg;
                        end
                    end
                    if (right_target_reg != 8'd0)
                    begin
                        if (right_dir_reg)
                        begin
                            ra_next = right_duty_reg;
                        end
                        else
                        begin
                            rb_next = right_duty_reg;
                        end
                    end
                    state_next = dwsr_pkg::ST_IDLE;
                end
            end

            default:
                state_next = dwsr_pkg::ST_IDLE;
        endcase
    end

    // Control and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dwsr_pkg::ST_IDLE;
            left_dir_reg     <= 1'b1;
            left_target_reg  <= 8'd0;
            left_meas_reg    <= 8'd0;
            left_duty_reg    <= 8'd0;
            left_count_reg   <= 8'd0;
            right_dir_reg    <= 1'b1;
            right_target_reg <= 8'd0;
            right_meas_reg   <= 8'd0;
            right_duty_reg   <= 8'd0;
            right_count_reg  <= 8'd0;
            addr_reg         <= 4'd0;
            oor_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            left_dir_reg     <= left_dir_next;
            left_target_reg  <= left_target_next;
            left_meas_reg    <= left_meas_next;
            left_duty_reg    <= left_duty_next;
            left_count_reg   <= left_count_next;
            right_dir_reg    <= right_dir_next;
            right_target_reg <= right_target_next;
            right_meas_reg   <= right_meas_next;
            right_duty_reg   <= right_duty_next;
            right_count_reg  <= right_count_next;
            addr_reg         <= addr_next;
            oor_reg          <= oor_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        rdata_reg <= rdata_next;
        last_reg  <= last_next;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = kind_reg;
    assign read_data        = rdata_reg;
    assign last_byte        = last_reg;
    assign left_leg_a_duty  = la_reg;
    assign left_leg_b_duty  = lb_reg;
    assign right_leg_a_duty = ra_reg;
    assign right_leg_b_duty = rb_reg;

    // Checks
    `DWSR_ASSERT_NOW(a_read_no_drive,
        out_valid && (result_kind == dwsr_pkg::KIND_READ),
        (left_leg_a_duty == 8'd0) && (left_leg_b_duty == 8'd0) &&
        (right_leg_a_duty == 8'd0) && (right_leg_b_duty == 8'd0),
        "read result carries drive levels")
    `DWSR_ASSERT_NOW(a_one_leg,
        out_valid && (result_kind == dwsr_pkg::KIND_DRIVE),
        !((left_leg_a_duty != 8'd0) && (left_leg_b_duty != 8'd0)) &&
        !((right_leg_a_duty != 8'd0) && (right_leg_b_duty != 8'd0)) &&
        (read_data == 8'd0) && !last_byte,
        "drive result on both legs or with read data")
    `DWSR_ASSERT_NEXT(a_burst_continues,
        out_valid && out_ready && (result_kind == dwsr_pkg::KIND_READ) && !last_byte,
        out_valid && (result_kind == dwsr_pkg::KIND_READ),
        "read burst broke off before its last byte")

endmodule

// File: tb/tb_dual_wheel_speed_regulator.sv
// Self-checking testbench for the dual wheel speed regulator.
// Depends on dwsr_pkg and dual_wheel_speed_regulator; a scoreboard class predicts
// every read byte and drive update; a task drives in_valid, an always block out_ready.
module tb_dual_wheel_speed_regulator;
    import dwsr_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          TOTAL_ITEMS  = 130;
    localparam logic [2:0]  ACT_SPARE_LO = ACT_TICK + 3'd1;
    localparam logic [2:0]  ACT_SPARE_HI = 3'b111;

    // One result transfer as seen on the output channel
    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic [7:0] l_a;
        logic [7:0] l_b;
        logic [7:0] r_a;
        logic [7:0] r_b;
    } regulator_result_t;

    // Tracks register map, edge counters and duties; queues the expected results
    class regulator_scoreboard;
        logic              left_dir, right_dir;
        logic [7:0]        left_target, left_measured, left_duty, left_edges;
        logic [7:0]        right_target, right_measured, right_duty, right_edges;
        regulator_result_t expected_results[$];
        int                mismatches;

        function new();
            left_dir       = 1'b1;
            right_dir      = 1'b1;
            left_target    = '0;
            left_measured  = '0;
            left_duty      = '0;
            left_edges     = '0;
            right_target   = '0;
            right_measured = '0;
            right_duty     = '0;
            right_edges    = '0;
            mismatches     = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function logic [7:0] reg_byte(logic [3:0] idx);
            case (idx)
                REG_ID:       return DEVICE_ID;
                REG_VERSION:  return VERSION_ID;
                REG_L_DIR:    return {7'd0, left_dir};
                REG_L_TARGET: return left_target;
                REG_L_MEAS:   return left_measured;
                REG_L_DUTY:   return left_duty;
                REG_R_DIR:    return {7'd0, right_dir};
                REG_R_TARGET: return right_target;
                REG_R_MEAS:   return right_measured;
                REG_R_DUTY:   return right_duty;
                default:      return 8'd0;
            endcase
        endfunction

        // Latch the edge count as speed, clear it, step the duty toward the target
        function void regulate_wheel(inout logic [7:0] edges, inout logic [7:0] measured,
                                     input logic [7:0] target, inout logic [7:0] duty);
            measured = edges;
            edges    = '0;
            if (measured < target && duty != BYTE_MAX)
                duty = duty + 8'd1;
            else if (measured > target && duty != 8'd0)
                duty = duty - 8'd1;
        endfunction

        function void note_transfer(logic [2:0] act, logic [7:0] addr, logic [7:0] data);
            regulator_result_t r;
            int                a;
            r = '{default: '0};
            case (act)
                ACT_WRITE:
                begin
                    if (addr[7:4] == 4'd0)
                    begin
                        case (addr[3:0])
                            REG_L_DIR: left_dir  = (data != 8'd0);
                            REG_R_DIR: right_dir = (data != 8'd0);
                            REG_L_TARGET:
                            begin
                                left_target = data;
                                if (data == 8'd0)
                                    left_duty = '0;
                            end
                            REG_R_TARGET:
                            begin
                                right_target = data;
                                if (data == 8'd0)
                                    right_duty = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_READ:
                begin
                    r.kind = KIND_READ;
                    if (addr >= NUM_REGS)
                    begin
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        for (a = int'(addr); a < int'(NUM_REGS); a++)
                        begin
                            r.data = reg_byte(4'(a));
                            r.last = (a == int'(NUM_REGS) - 1);
                            expected_results.push_back(r);
                        end
                    end
                end
                ACT_LEFT:
                begin
                    if (left_edges != BYTE_MAX)
                        left_edges = left_edges + 8'd1;
                end
                ACT_RIGHT:
                begin
                    if (right_edges != BYTE_MAX)
                        right_edges = right_edges + 8'd1;
                end
                ACT_TICK:
                begin
                    regulate_wheel(left_edges, left_measured, left_target, left_duty);
                    regulate_wheel(right_edges, right_measured, right_target, right_duty);
                    r.kind = KIND_DRIVE;
                    if (left_target != 8'd0)
                    begin
                        if (left_dir)
                            r.l_a = left_duty;
                        else
                            r.l_b = left_duty;
                    end
                    if (right_target != 8'd0)
                    begin
                        if (right_dir)
                            r.r_a = right_duty;
                        else
                            r.r_b = right_duty;
                    end
                    expected_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(regulator_result_t got);
            regulator_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result_kind: expected no transfer, got %0d", got.kind);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 8'(want.kind), 8'(got.kind));
            compare_field("read_data", want.data, got.data);
            compare_field("last_byte", 8'(want.last), 8'(got.last));
            compare_field("left_leg_a_duty", want.l_a, got.l_a);
            compare_field("left_leg_b_duty", want.l_b, got.l_b);
            compare_field("right_leg_a_duty", want.r_a, got.r_a);
            compare_field("right_leg_b_duty", want.r_b, got.r_b);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       out_valid;
    logic       out_ready;
    logic       result_kind;
    logic [7:0] read_data;
    logic       last_byte;
    logic [7:0] left_leg_a_duty;
    logic [7:0] left_leg_b_duty;
    logic [7:0] right_leg_a_duty;
    logic [7:0] right_leg_b_duty;

    regulator_scoreboard regulator_sb;
    logic                steady;
    int                  stall_left;
    int                  counted_items;
    int                  cycle_count;

    dual_wheel_speed_regulator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .reg_addr         (reg_addr),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .read_data        (read_data),
        .last_byte        (last_byte),
        .left_leg_a_duty  (left_leg_a_duty),
        .left_leg_b_duty  (left_leg_b_duty),
        .right_leg_a_duty (right_leg_a_duty),
        .right_leg_b_duty (right_leg_b_duty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Present one item, hold it until the transfer, then log it
    task automatic send_item(input logic [2:0] act, input logic [7:0] addr,
                             input logic [7:0] data);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        reg_addr   <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        regulator_sb.note_transfer(act, addr, data);
        counted_items++;
    endtask

    // One control period: maybe retune a wheel, feed encoder edges, tick, maybe read back
    task automatic control_period();
        int         n_left, n_right, sel;
        logic [7:0] addr, data;
        if ($urandom_range(0, 9) < 4)
        begin
            sel = $urandom_range(0, 3);
            addr = (sel == 0) ? 8'(REG_L_DIR) : (sel == 1) ? 8'(REG_L_TARGET) :
                   (sel == 2) ? 8'(REG_R_DIR) : 8'(REG_R_TARGET);
            sel = $urandom_range(0, 9);
            if (sel < 2)
                data = 8'd0;
            else if (sel < 8)
                data = 8'($urandom_range(1, 15));
            else
                data = 8'($urandom_range(0, 255));
            send_item(ACT_WRITE, addr, data);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            n_left  = $urandom_range(0, 20);
            n_right = $urandom_range(0, 20);
        end
        else
        begin
            n_left  = $urandom_range(0, 5);
            n_right = $urandom_range(0, 5);
        end
        // Interleave the two encoders at random
        while (n_left + n_right > 0)
        begin
            if (n_right == 0 || (n_left > 0 && $urandom_range(0, 1) == 0))
            begin
                send_item(ACT_LEFT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                n_left--;
            end
            else
            begin
                send_item(ACT_RIGHT, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                n_right--;
            end
        end
        send_item(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 19);
        if (sel < 5)
            send_item(ACT_READ, 8'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
        else if (sel == 5)
            send_item(ACT_READ, 8'($urandom_range(10, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Check each result transfer and pace the receiver
    always @(posedge clk)
    begin
        regulator_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = result_kind;
            got.data = read_data;
            got.last = last_byte;
            got.l_a  = left_leg_a_duty;
            got.l_b  = left_leg_b_duty;
            got.r_a  = right_leg_a_duty;
            got.r_b  = right_leg_b_duty;
            regulator_sb.check_result(got);
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_dual_wheel_speed_regulator: done, errors");
            $finish;
        end
    end

    initial
    begin
        regulator_sb  = new();
        steady        = 1'b0;
        stall_left    = 0;
        counted_items = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_WRITE;
        reg_addr      = '0;
        write_data    = '0;
        out_ready     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full and short bursts, out-of-range reads, every write kind, edges, ticks, spare actions
        send_item(ACT_READ, 8'(REG_ID), 8'd0);
        send_item(ACT_READ, 8'(REG_LAST), 8'd0);
        send_item(ACT_READ, NUM_REGS, 8'd0);
        send_item(ACT_READ, 8'hFF, 8'hFF);
        send_item(ACT_WRITE, 8'(REG_L_DIR), 8'd0);
        send_item(ACT_WRITE, 8'(REG_R_DIR), 8'h80);
        send_item(ACT_WRITE, 8'(REG_L_TARGET), BYTE_MAX);
        send_item(ACT_WRITE, 8'(REG_R_TARGET), 8'd1);
        send_item(ACT_WRITE, 8'(REG_ID), 8'hFF);
        send_item(ACT_WRITE, 8'hFF, 8'h5A);
        repeat (3) send_item(ACT_LEFT, 8'd0, 8'd0);
        repeat (2) send_item(ACT_RIGHT, 8'hFF, 8'hFF);
        // Right wheel is above target with duty at zero: duty must hold
        send_item(ACT_TICK, 8'd0, 8'd0);
        // No edges since the last tick: both speeds drop to zero
        send_item(ACT_TICK, 8'hFF, 8'hFF);
        send_item(ACT_READ, 8'(REG_L_DIR), 8'd0);
        send_item(ACT_SPARE_LO, 8'(REG_L_TARGET), 8'd0);
        send_item(ACT_SPARE_HI, 8'hFF, 8'hFF);
        // Zero target clears the duty and silences both legs
        send_item(ACT_WRITE, 8'(REG_L_TARGET), 8'd0);
        send_item(ACT_TICK, 8'd0, 8'd0);
        send_item(ACT_READ, 8'(REG_L_MEAS), 8'd0);
        send_item(ACT_SPARE_LO + 3'd1, 8'(REG_R_TARGET), 8'd0);

        // Random: mostly well-formed control periods, some raw noise
        while (counted_items < TOTAL_ITEMS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7)
                control_period();
            else
                repeat ($urandom_range(1, 4))
                    send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        // Drain
        while (regulator_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (regulator_sb.mismatches == 0 && regulator_sb.outstanding() == 0)
            $display("tb_dual_wheel_speed_regulator: done, clean");
        else
            $display("tb_dual_wheel_speed_regulator: done, errors");
        $finish;
    end

endmodule
